// File: rtl/cdsw_pkg.sv
// shared types, codes and constants for the character display shadow writer
// no dependencies; imported by cdsw_in_if, cdsw_ctrl, cdsw_datapath and the top level
`default_nettype none

package cdsw_pkg;

    localparam int CDSW_COLS = 20;
    localparam int CDSW_ROWS = 4;

    localparam int COL_W     = 5;
    localparam int ROW_W     = 2;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] SPACE_CODE          = 8'h20;
    localparam logic [7:0] RST_SPECIAL_PREFIX  = 8'd254;
    localparam logic [7:0] RST_SETTING_PREFIX  = 8'd124;
    localparam logic [7:0] RST_CLEAR_CODE      = 8'd45;
    localparam logic [7:0] RST_ADDRESS_BASE    = 8'd128;

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 2'd0,
        OP_CURSOR = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPECIAL_PREFIX = 2'd0,
        CFG_SETTING_PREFIX = 2'd1,
        CFG_CLEAR_CODE     = 2'd2,
        CFG_ADDRESS_BASE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic capture;
        logic plan;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic mask_empty;
        logic last_word;
        logic out_free;
    } t_sts;

    // display address of the first cell of each row
    function automatic logic [7:0] row_start(input logic [ROW_W-1:0] row);
        logic [7:0] v;
        unique case (row)
            2'd0: v = 8'h00;
            2'd1: v = 8'h40;
            2'd2: v = 8'h14;
            default: v = 8'h54;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/cdsw_in_if.sv
// input channel of the shadow writer: valid, ready and one operation word
// depends on cdsw_pkg
`default_nettype none

interface cdsw_in_if import cdsw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [7:0]          char_code;
    logic                string_end;
    logic signed [7:0]   col;
    logic signed [7:0]   row;

    modport source (output valid, operation, char_code, string_end, col, row, input ready);
    modport sink   (input valid, operation, char_code, string_end, col, row, output ready);
endinterface

`default_nettype wire

// File: rtl/cdsw_out_if.sv
// output channel of the shadow writer: valid, ready and one bus word
// depends on nothing
`default_nettype none

interface cdsw_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] bus_byte;
    logic       last;

    modport source (output valid, kind, bus_byte, last, input ready);
    modport sink   (input valid, kind, bus_byte, last, output ready);
endinterface

`default_nettype wire

// File: rtl/cdsw_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module cdsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/cdsw_ctrl.sv
// controller state machine: accept, shadow lookup, plan, word emission
// depends on cdsw_pkg
`default_nettype none

module cdsw_ctrl import cdsw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_PLAN,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                n_state = S_PLAN;
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.mask_empty) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_word) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = r_ready;

endmodule

`default_nettype wire

// File: rtl/cdsw_datapath.sv
// datapath: config registers, cursor, shadow store, word plan and output register
// depends on cdsw_pkg and cdsw_ram
`default_nettype none

module cdsw_datapath import cdsw_pkg::*; #(
    parameter int COLS = CDSW_COLS,
    parameter int ROWS = CDSW_ROWS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [7:0]            i_char_code,
    input  wire logic                  i_string_end,
    input  wire logic signed [7:0]     i_col,
    input  wire logic signed [7:0]     i_row,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [7:0]            i_cfg_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_kind,
    output logic [7:0]                 o_bus_byte,
    output logic                       o_last
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int NSTEP = 9;

    // result words in emission order
    localparam logic [NSTEP-1:0] M_PRESTOP  = 9'b0_0000_0001;
    localparam logic [NSTEP-1:0] M_PFX      = 9'b0_0000_0010;
    localparam logic [NSTEP-1:0] M_ADDR     = 9'b0_0000_0100;
    localparam logic [NSTEP-1:0] M_ASTOP    = 9'b0_0000_1000;
    localparam logic [NSTEP-1:0] M_CHAR     = 9'b0_0001_0000;
    localparam logic [NSTEP-1:0] M_SETP     = 9'b0_0010_0000;
    localparam logic [NSTEP-1:0] M_CLR      = 9'b0_0100_0000;
    localparam logic [NSTEP-1:0] M_CSTOP    = 9'b0_1000_0000;
    localparam logic [NSTEP-1:0] M_POSTSTOP = 9'b1_0000_0000;
    localparam logic [NSTEP-1:0] M_STOPS    = M_PRESTOP | M_ASTOP | M_CSTOP | M_POSTSTOP;

    localparam logic [AW-1:0] COLS_A = AW'(COLS);

    logic [7:0]        r_special_prefix, r_setting_prefix, r_clear_code, r_address_base;
    logic [OP_W-1:0]   r_op;
    logic [7:0]        r_char;
    logic              r_end;
    logic [7:0]        r_col_req, r_row_req;
    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic              r_run_open, n_run_open;
    logic [CELLS-1:0]  r_valid, n_valid;
    logic [NSTEP-1:0]  r_mask, n_mask;
    logic [7:0]        r_addr, n_addr;
    logic              r_out_valid, r_out_kind, r_out_last;
    logic [7:0]        r_out_byte;

    logic [AW-1:0]     w_idx;
    logic [7:0]        w_rdata, w_cell;
    logic              w_we, w_differs, w_wrap, w_run_after, w_close;
    logic [COL_W:0]    w_col_inc;
    logic [ROW_W:0]    w_row_inc;
    logic [NSTEP-1:0]  w_pick, w_rest;
    logic [7:0]        w_byte;

    assign w_idx = AW'(r_cur_row) * COLS_A + AW'(r_cur_col);

    cdsw_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_shadow (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx),
        .i_wdata (r_char),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    // plan of one operation
    always_comb begin
        w_cell      = r_valid[w_idx] ? w_rdata : SPACE_CODE;
        w_differs   = (w_cell != r_char);
        w_col_inc   = {1'b0, r_cur_col} + 1'b1;
        w_row_inc   = {1'b0, r_cur_row} + 1'b1;
        w_wrap      = (w_col_inc >= (COL_W + 1)'(COLS));
        w_run_after = r_run_open;
        w_close     = 1'b0;
        w_we        = 1'b0;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_run_open  = r_run_open;
        n_valid     = r_valid;
        n_mask      = '0;
        n_addr      = r_address_base | (8'(r_cur_col) + row_start(r_cur_row));
        unique case (r_op)
            OP_PUT: begin
                if (w_differs) begin
                    w_we           = i_cmd.plan;
                    n_valid[w_idx] = 1'b1;
                    if (!r_run_open) begin
                        n_mask = n_mask | M_PFX | M_ADDR | M_ASTOP;
                    end
                    n_mask      = n_mask | M_CHAR;
                    w_run_after = 1'b1;
                end else begin
                    if (r_run_open) begin
                        n_mask = n_mask | M_PRESTOP;
                    end
                    w_run_after = 1'b0;
                end
                if (w_wrap) begin
                    n_cur_col = '0;
                    n_cur_row = (w_row_inc >= (ROW_W + 1)'(ROWS)) ? '0 : w_row_inc[ROW_W-1:0];
                end else begin
                    n_cur_col = w_col_inc[COL_W-1:0];
                end
                w_close = w_wrap || r_end;
                if (w_close && w_run_after) begin
                    n_mask = n_mask | M_POSTSTOP;
                end
                n_run_open = w_run_after && !w_close;
            end
            OP_CURSOR: begin
                if (r_run_open) begin
                    n_mask = M_PRESTOP;
                end
                n_run_open = 1'b0;
                if (r_col_req[7]) begin
                    n_cur_col = '0;
                end else if (r_col_req[6:0] > 7'(COLS - 1)) begin
                    n_cur_col = COL_W'(COLS - 1);
                end else begin
                    n_cur_col = r_col_req[COL_W-1:0];
                end
                if (r_row_req[7]) begin
                    n_cur_row = '0;
                end else if (r_row_req[6:0] > 7'(ROWS - 1)) begin
                    n_cur_row = ROW_W'(ROWS - 1);
                end else begin
                    n_cur_row = r_row_req[ROW_W-1:0];
                end
            end
            OP_CLEAR: begin
                n_mask = M_SETP | M_CLR | M_CSTOP;
                if (r_run_open) begin
                    n_mask = n_mask | M_PRESTOP;
                end
                n_run_open = 1'b0;
                n_valid    = '0;
                n_cur_col  = '0;
                n_cur_row  = '0;
            end
            default: ;
        endcase
    end

    // next word from the plan, lowest pending step first
    always_comb begin
        w_pick = r_mask & (~r_mask + 1'b1);
        w_rest = r_mask & ~w_pick;
        w_byte = ({8{|(w_pick & M_PFX)}}  & r_special_prefix)
               | ({8{|(w_pick & M_ADDR)}} & r_addr)
               | ({8{|(w_pick & M_CHAR)}} & r_char)
               | ({8{|(w_pick & M_SETP)}} & r_setting_prefix)
               | ({8{|(w_pick & M_CLR)}}  & r_clear_code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_special_prefix <= RST_SPECIAL_PREFIX;
            r_setting_prefix <= RST_SETTING_PREFIX;
            r_clear_code     <= RST_CLEAR_CODE;
            r_address_base   <= RST_ADDRESS_BASE;
            r_cur_col        <= '0;
            r_cur_row        <= '0;
            r_run_open       <= 1'b0;
            r_valid          <= '0;
            r_mask           <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SPECIAL_PREFIX: r_special_prefix <= i_cfg_data;
                    CFG_SETTING_PREFIX: r_setting_prefix <= i_cfg_data;
                    CFG_CLEAR_CODE:     r_clear_code     <= i_cfg_data;
                    CFG_ADDRESS_BASE:   r_address_base   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.capture) begin
                r_op      <= i_operation;
                r_char    <= i_char_code;
                r_end     <= i_string_end;
                r_col_req <= i_col;
                r_row_req <= i_row;
            end
            if (i_cmd.plan) begin
                r_cur_col  <= n_cur_col;
                r_cur_row  <= n_cur_row;
                r_run_open <= n_run_open;
                r_valid    <= n_valid;
                r_mask     <= n_mask;
                r_addr     <= n_addr;
            end else if (i_cmd.emit) begin
                r_mask <= w_rest;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_out_kind  <= |(w_pick & M_STOPS);
                r_out_byte  <= w_byte;
                r_out_last  <= (w_rest == '0);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.mask_empty = (r_mask == '0);
    assign o_sts.last_word  = (w_rest == '0);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_bus_byte  = r_out_byte;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

// File: rtl/char_display_shadow_writer_top.sv
// an operation is accepted in idle, looked up in the shadow store and planned, then
// its result words go out in order whenever the output register is free; it may
// yield none, and the next operation is accepted once its last word is issued
// the output register lets the input take a new operation while a word waits
// synchronous active-low reset: cursor home, no open run, shadow reads as spaces
// at once through per-cell valid bits, config registers return to defaults
`default_nettype none

module char_display_shadow_writer_top import cdsw_pkg::*; #(
    parameter int COLS = CDSW_COLS,
    parameter int ROWS = CDSW_ROWS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    cdsw_in_if.sink                   i_in,
    cdsw_out_if.source                o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]           i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    cdsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cdsw_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_operation  (i_in.operation),
        .i_char_code  (i_in.char_code),
        .i_string_end (i_in.string_end),
        .i_col        (i_in.col),
        .i_row        (i_in.row),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_kind       (o_out.kind),
        .o_bus_byte   (o_out.bus_byte),
        .o_last       (o_out.last)
    );

endmodule

`default_nettype wire

// File: rtl/cdsw_checker.sv
// port-level checks of the shadow writer, bound to the top level
// depends on char_display_shadow_writer_top
`default_nettype none

module cdsw_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_kind,
    input wire logic [7:0] i_bus_byte,
    input wire logic       i_last
);

    // a waiting word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    // a waiting word keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_kind) && $stable(i_bus_byte) && $stable(i_last))
        else $error("output word changed while stalled");

    // one operation at a time: input closes right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input still ready after an accept");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind char_display_shadow_writer_top cdsw_checker u_cdsw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.kind),
    .i_bus_byte  (o_out.bus_byte),
    .i_last      (o_out.last)
);

`default_nettype wire
